>>> design/sog_pkg.sv
// Shared types, constants and helper functions of the sub-octave generator.
`timescale 1ns / 1ps

package sog_pkg;

  // Working precision: products and sums live in a 40-bit accumulator.
  localparam int ACC_W = 40;

  // Microprogram counter width and the entry point of the final mix.
  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] MIX_PC = 5'd22;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_EQ_COEFF   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DC_STEP    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASS_TRIM  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SUB_GAIN   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WET_GAIN   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_DRY_GAIN   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_LIGHT_MODE = 3'd6;

  // Unity in unsigned Q1.30.
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  localparam logic signed [ACC_W-1:0] S32_MAX = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0] S32_MIN = -40'sd2147483648;

  typedef struct packed {
    logic [30:0] eq_coeff;
    logic [30:0] dc_step;
    logic [31:0] bass_trim;
    logic [31:0] sub_gain;
    logic [30:0] wet_gain;
    logic [30:0] dry_gain;
    logic        light_mode;
  } cfg_t;

  // Multiplier operand A (signed state or temporary).
  typedef enum logic [2:0] {
    A_LP, A_INTEG, A_F1, A_F2, A_XQ, A_TMP, A_AV
  } opa_e;

  // Multiplier operand B (coefficient, or the working value a for the cube).
  typedef enum logic [2:0] {
    B_REMAIN, B_EQ, B_SUBG, B_BASS, B_DRY, B_WET, B_AV
  } opb_e;

  typedef enum logic [2:0] {
    ACC_NOP, ACC_LDP, ACC_ADDP, ACC_SUBP, ACC_LDA, ACC_DC
  } acc_e;

  // Source of a direct accumulator load.
  typedef enum logic [1:0] {
    L_XQ, L_INTEG, L_AV
  } lds_e;

  // Destination of the saturated accumulator result.
  typedef enum logic [2:0] {
    D_NONE, D_LPR, D_TMP, D_AV, D_INTEG, D_F1, D_F2, D_OUT
  } dst_e;

  typedef enum logic [1:0] {
    FL_NEXT, FL_LIGHT, FL_END
  } flow_e;

  typedef struct packed {
    logic  ldx;
    logic  mul_en;
    opa_e  a_sel;
    opb_e  b_sel;
    logic  sh28;
    acc_e  acc_op;
    lds_e  ld_sel;
    dst_e  dst;
    flow_e flow;
  } ucode_t;

  function automatic ucode_t uw(logic ldx, logic mul_en, opa_e a_sel, opb_e b_sel,
                                logic sh28, acc_e acc_op, lds_e ld_sel, dst_e dst,
                                flow_e flow);
    ucode_t w;
    w.ldx    = ldx;
    w.mul_en = mul_en;
    w.a_sel  = a_sel;
    w.b_sel  = b_sel;
    w.sh28   = sh28;
    w.acc_op = acc_op;
    w.ld_sel = ld_sel;
    w.dst    = dst;
    w.flow   = flow;
    return w;
  endfunction

  // Saturate an accumulator value to signed 32 bits.
  function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] c;
    if (v > S32_MAX) begin
      c = S32_MAX;
    end else if (v < S32_MIN) begin
      c = S32_MIN;
    end else begin
      c = v;
    end
    return $signed(c[31:0]);
  endfunction

endpackage

>>> design/sog_ucode_rom.sv
// Microprogram of one channel: one control word per step.
`timescale 1ns / 1ps

module sog_ucode_rom (
  input  logic [sog_pkg::PC_W-1:0] pc_i,
  output sog_pkg::ucode_t          ctrl_o
);

  // A multiply issued in one step is consumed by the accumulator in the next.
  always_comb begin
    case (pc_i)
      // Input lowpass: d = lp*(1-eq) + xq*eq, then rectify with the octave flag.
      5'd0: ctrl_o = sog_pkg::uw(1'b1, 1'b1, sog_pkg::A_LP, sog_pkg::B_REMAIN, 1'b0,
                                 sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                 sog_pkg::FL_NEXT);
      5'd1: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_XQ, sog_pkg::B_EQ, 1'b0,
                                 sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                 sog_pkg::FL_NEXT);
      5'd2: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_XQ, sog_pkg::B_EQ, 1'b0,
                                 sog_pkg::ACC_ADDP, sog_pkg::L_XQ, sog_pkg::D_LPR,
                                 sog_pkg::FL_NEXT);
      // t = rect*sub_gain + xq
      5'd3: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_TMP, sog_pkg::B_SUBG, 1'b0,
                                 sog_pkg::ACC_LDA, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                 sog_pkg::FL_NEXT);
      5'd4: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_SUBG, 1'b0,
                                 sog_pkg::ACC_ADDP, sog_pkg::L_XQ, sog_pkg::D_TMP,
                                 sog_pkg::FL_NEXT);
      // a = integ + t*eq
      5'd5: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                 sog_pkg::ACC_LDA, sog_pkg::L_INTEG, sog_pkg::D_NONE,
                                 sog_pkg::FL_NEXT);
      5'd6: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                 sog_pkg::ACC_ADDP, sog_pkg::L_XQ, sog_pkg::D_AV,
                                 sog_pkg::FL_NEXT);
      // Cube in Q4.28: (a*a) then (a*a)*a.
      5'd7: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_AV, sog_pkg::B_AV, 1'b1,
                                 sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                 sog_pkg::FL_NEXT);
      5'd8: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_AV, sog_pkg::B_AV, 1'b1,
                                 sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_TMP,
                                 sog_pkg::FL_NEXT);
      5'd9: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_TMP, sog_pkg::B_AV, 1'b1,
                                 sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                 sog_pkg::FL_NEXT);
      5'd10: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_AV, 1'b1,
                                  sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_TMP,
                                  sog_pkg::FL_NEXT);
      // a = a - cube*eq, then the pull toward zero.
      5'd11: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_LDA, sog_pkg::L_AV, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd12: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_SUBP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd13: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_DC, sog_pkg::L_XQ, sog_pkg::D_INTEG,
                                  sog_pkg::FL_NEXT);
      // Bass trim.
      5'd14: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_INTEG, sog_pkg::B_BASS, 1'b0,
                                  sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd15: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_INTEG, sog_pkg::B_BASS, 1'b0,
                                  sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_TMP,
                                  sog_pkg::FL_NEXT);
      // First output lowpass; light mode skips the second.
      5'd16: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_F1, sog_pkg::B_REMAIN, 1'b0,
                                  sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd17: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd18: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_ADDP, sog_pkg::L_XQ, sog_pkg::D_F1,
                                  sog_pkg::FL_LIGHT);
      // Second output lowpass.
      5'd19: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_F2, sog_pkg::B_REMAIN, 1'b0,
                                  sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd20: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_F1, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd21: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_F1, sog_pkg::B_EQ, 1'b0,
                                  sog_pkg::ACC_ADDP, sog_pkg::L_XQ, sog_pkg::D_F2,
                                  sog_pkg::FL_NEXT);
      // Wet and dry mix.
      5'd22: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_XQ, sog_pkg::B_DRY, 1'b0,
                                  sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd23: ctrl_o = sog_pkg::uw(1'b0, 1'b1, sog_pkg::A_TMP, sog_pkg::B_WET, 1'b0,
                                  sog_pkg::ACC_LDP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                  sog_pkg::FL_NEXT);
      5'd24: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_TMP, sog_pkg::B_WET, 1'b0,
                                  sog_pkg::ACC_ADDP, sog_pkg::L_XQ, sog_pkg::D_OUT,
                                  sog_pkg::FL_END);
      default: ctrl_o = sog_pkg::uw(1'b0, 1'b0, sog_pkg::A_XQ, sog_pkg::B_EQ, 1'b0,
                                    sog_pkg::ACC_NOP, sog_pkg::L_XQ, sog_pkg::D_NONE,
                                    sog_pkg::FL_END);
    endcase
  end

endmodule

>>> design/sog_datapath.sv
// Datapath: shared multiplier, accumulator, temporaries and per-channel filter state.
`timescale 1ns / 1ps

module sog_datapath #(
  parameter int SAMPLE_BITS = 24,
  parameter int CHANNELS    = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_en_i,
  input  logic                          ch_i,
  input  sog_pkg::ucode_t               ctrl_i,
  input  sog_pkg::cfg_t                 cfg_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] out_o,
  output logic signed [SAMPLE_BITS-1:0] left_o
);

  localparam int ACC_W = sog_pkg::ACC_W;
  localparam int LSH   = (SAMPLE_BITS <= 29) ? 29 - SAMPLE_BITS : 0;
  localparam int RSH   = (SAMPLE_BITS > 29) ? SAMPLE_BITS - 29 : 0;
  localparam logic signed [47:0] OUT_MAX = (48'sd1 <<< (SAMPLE_BITS - 1)) - 48'sd1;
  localparam logic signed [47:0] OUT_MIN = -OUT_MAX - 48'sd1;

  // Per-channel state.
  logic signed [31:0] lp_q    [CHANNELS];
  logic signed [31:0] integ_q [CHANNELS];
  logic signed [31:0] f1_q    [CHANNELS];
  logic signed [31:0] f2_q    [CHANNELS];
  logic               below_q [CHANNELS];
  logic               flag_q  [CHANNELS];

  // Working registers.
  logic signed [31:0]      xq_q, tmp_q, av_q;
  logic signed [64:0]      prod_q;
  logic                    sh28_q;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [SAMPLE_BITS-1:0] left_q;

  logic signed [31:0] lp_rd, integ_rd, f1_rd, f2_rd;
  logic               flag_rd;
  logic [30:0]        eq_c, remain;
  logic signed [31:0] opa, opl, xq_d, res32, absd, rect;
  logic signed [32:0] opb;
  logic signed [64:0] prod_d, p_sh;
  logic signed [ACC_W-1:0] pval, s_acc, dc_ext;
  logic signed [47:0] so_w, so_sat;
  logic               x_pos;

  // A single-channel build reads entry zero only.
  assign lp_rd    = (ch_i && (CHANNELS > 1)) ? lp_q[CHANNELS-1]    : lp_q[0];
  assign integ_rd = (ch_i && (CHANNELS > 1)) ? integ_q[CHANNELS-1] : integ_q[0];
  assign f1_rd    = (ch_i && (CHANNELS > 1)) ? f1_q[CHANNELS-1]    : f1_q[0];
  assign f2_rd    = (ch_i && (CHANNELS > 1)) ? f2_q[CHANNELS-1]    : f2_q[0];
  assign flag_rd  = (ch_i && (CHANNELS > 1)) ? flag_q[CHANNELS-1]  : flag_q[0];

  // A coefficient above one is used as one, so the remainder stays non-negative.
  assign eq_c   = (cfg_i.eq_coeff > sog_pkg::ONE_Q30) ? sog_pkg::ONE_Q30 : cfg_i.eq_coeff;
  assign remain = sog_pkg::ONE_Q30 - eq_c;

  assign xq_d  = (32'(sample_i) <<< LSH) >>> RSH;
  assign x_pos = !sample_i[SAMPLE_BITS-1] && (sample_i != '0);

  always_comb begin
    case (ctrl_i.a_sel)
      sog_pkg::A_LP:    opa = lp_rd;
      sog_pkg::A_INTEG: opa = integ_rd;
      sog_pkg::A_F1:    opa = f1_rd;
      sog_pkg::A_F2:    opa = f2_rd;
      sog_pkg::A_XQ:    opa = xq_q;
      sog_pkg::A_TMP:   opa = tmp_q;
      sog_pkg::A_AV:    opa = av_q;
      default:          opa = xq_q;
    endcase
  end

  always_comb begin
    case (ctrl_i.b_sel)
      sog_pkg::B_REMAIN: opb = $signed({2'b00, remain});
      sog_pkg::B_EQ:     opb = $signed({2'b00, eq_c});
      sog_pkg::B_SUBG:   opb = $signed({1'b0, cfg_i.sub_gain});
      sog_pkg::B_BASS:   opb = $signed({1'b0, cfg_i.bass_trim});
      sog_pkg::B_DRY:    opb = $signed({2'b00, cfg_i.dry_gain});
      sog_pkg::B_WET:    opb = $signed({2'b00, cfg_i.wet_gain});
      sog_pkg::B_AV:     opb = 33'(av_q);
      default:           opb = $signed({2'b00, eq_c});
    endcase
  end

  always_comb begin
    case (ctrl_i.ld_sel)
      sog_pkg::L_XQ:    opl = xq_q;
      sog_pkg::L_INTEG: opl = integ_rd;
      sog_pkg::L_AV:    opl = av_q;
      default:          opl = xq_q;
    endcase
  end

  assign prod_d = opa * opb;

  // Arithmetic shift of the registered product rounds toward minus infinity.
  assign p_sh = sh28_q ? (prod_q >>> 28) : (prod_q >>> 30);
  assign pval = $signed(p_sh[ACC_W-1:0]);

  assign s_acc  = ACC_W'(sog_pkg::sat32(acc_q));
  assign dc_ext = $signed({{(ACC_W-29){1'b0}}, cfg_i.dc_step[30:2]});

  always_comb begin
    case (ctrl_i.acc_op)
      sog_pkg::ACC_NOP:  acc_d = acc_q;
      sog_pkg::ACC_LDP:  acc_d = pval;
      sog_pkg::ACC_ADDP: acc_d = acc_q + pval;
      sog_pkg::ACC_SUBP: acc_d = acc_q - pval;
      sog_pkg::ACC_LDA:  acc_d = ACC_W'(opl);
      // An integrator at exactly zero is pulled upward.
      sog_pkg::ACC_DC:   acc_d = (s_acc > 0) ? s_acc - dc_ext : s_acc + dc_ext;
      default:           acc_d = acc_q;
    endcase
  end

  assign res32 = sog_pkg::sat32(acc_d);

  // Full-wave rectify, then apply the sign of the divide-by-two flag.
  assign absd = (res32 == 32'sh8000_0000) ? 32'sh7FFF_FFFF :
                (res32[31] ? -res32 : res32);
  assign rect = flag_rd ? absd : -absd;

  // The mix goes to the sample format without the 32-bit clamp.
  assign so_w   = (48'(acc_d) >>> LSH) <<< RSH;
  assign so_sat = (so_w > OUT_MAX) ? OUT_MAX : ((so_w < OUT_MIN) ? OUT_MIN : so_w);
  assign out_o  = $signed(so_sat[SAMPLE_BITS-1:0]);
  assign left_o = left_q;

  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      acc_q <= acc_d;
      if (ctrl_i.mul_en) begin
        prod_q <= prod_d;
        sh28_q <= ctrl_i.sh28;
      end
      if (ctrl_i.ldx) begin
        xq_q <= xq_d;
      end
      case (ctrl_i.dst)
        sog_pkg::D_LPR: tmp_q <= rect;
        sog_pkg::D_TMP,
        sog_pkg::D_F1,
        sog_pkg::D_F2:  tmp_q <= res32;
        sog_pkg::D_AV:  av_q  <= res32;
        sog_pkg::D_OUT: begin
          if (!ch_i) begin
            left_q <= out_o;
          end
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < CHANNELS; i++) begin : g_ch
    logic wr;
    assign wr = step_en_i && (ch_i == 1'(i));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lp_q[i]    <= '0;
        integ_q[i] <= '0;
        f1_q[i]    <= '0;
        f2_q[i]    <= '0;
        below_q[i] <= 1'b0;
        flag_q[i]  <= 1'b0;
      end else if (wr) begin
        if (ctrl_i.ldx) begin
          // A rising zero crossing toggles the octave flag; zero counts as below.
          if (x_pos) begin
            if (below_q[i]) begin
              flag_q[i] <= !flag_q[i];
            end
            below_q[i] <= 1'b0;
          end else begin
            below_q[i] <= 1'b1;
          end
        end
        case (ctrl_i.dst)
          sog_pkg::D_LPR:   lp_q[i]    <= res32;
          sog_pkg::D_INTEG: integ_q[i] <= res32;
          sog_pkg::D_F1:    f1_q[i]    <= res32;
          sog_pkg::D_F2:    f2_q[i]    <= res32;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> design/sub_octave_generator_top.sv
// Top level of the sub-octave generator: stream ports, configuration, step sequencer.
// Each beat runs the microprogram once per processed channel pass, i.e. once in mono
//   and twice in stereo; light mode saves 3 steps per channel.
// A new beat is taken only once the previous one is finished; the rate is
//   set by the microprogram length on the one shared 32x33 multiplier.
// Reset: rst_ni clears the configuration, sequencer, filter state and the handshake asynchronously.
`timescale 1ns / 1ps

module sub_octave_generator_top #(
  parameter int SAMPLE_BITS = 24,
  parameter int CHANNELS    = 2
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [sog_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [sog_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // Input stream.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata fields from bit 0: left_sample, right_sample, zero fill to whole bytes.
  input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // tuser fields from bit 0: stereo.
  input  logic                             s_axis_tuser_i,
  // Output stream.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata fields from bit 0: left_out, right_out, zero fill to whole bytes.
  output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
  localparam int PC_W   = sog_pkg::PC_W;

  // The block works on one beat at a time. A beat is taken while idle, even if the
  // previous result still waits in the output register; the last microstep stalls
  // until that register is free. Each channel runs the same microprogram: the
  // step counter walks the control store, the light-mode jump skips the second
  // lowpass, and the end step either restarts for the right channel or finishes.

  sog_pkg::cfg_t   cfg_q;
  sog_pkg::ucode_t ctrl;

  logic            busy_q, busy_d;
  logic [PC_W-1:0] pc_q, pc_d;
  logic            ch_q, ch_d;
  logic            stereo_q;
  logic signed [SAMPLE_BITS-1:0] left_in_q, right_in_q;
  logic            m_valid_q, m_valid_d;
  logic signed [SAMPLE_BITS-1:0] m_left_q, m_left_d, m_right_q, m_right_d;

  logic accept, out_free, more, step_en, finish;
  logic signed [SAMPLE_BITS-1:0] dp_out, dp_left, dp_sample;

  assign s_axis_tready_o = !busy_q;
  assign accept          = s_axis_tvalid_i && !busy_q;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // Stereo runs the microprogram a second time on the right channel.
  assign more    = !ch_q && stereo_q && (CHANNELS > 1);
  assign step_en = busy_q && !((ctrl.flow == sog_pkg::FL_END) && !more && !out_free);
  assign finish  = step_en && (ctrl.flow == sog_pkg::FL_END) && !more;

  assign dp_sample = ch_q ? right_in_q : left_in_q;

  sog_ucode_rom u_rom (
    .pc_i   (pc_q),
    .ctrl_o (ctrl)
  );

  sog_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CHANNELS    (CHANNELS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .ch_i      (ch_q),
    .ctrl_i    (ctrl),
    .cfg_i     (cfg_q),
    .sample_i  (dp_sample),
    .out_o     (dp_out),
    .left_o    (dp_left)
  );

  // Configuration registers; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        sog_pkg::CFG_EQ_COEFF:   cfg_q.eq_coeff   <= cfg_wdata_i[30:0];
        sog_pkg::CFG_DC_STEP:    cfg_q.dc_step    <= cfg_wdata_i[30:0];
        sog_pkg::CFG_BASS_TRIM:  cfg_q.bass_trim  <= cfg_wdata_i;
        sog_pkg::CFG_SUB_GAIN:   cfg_q.sub_gain   <= cfg_wdata_i;
        sog_pkg::CFG_WET_GAIN:   cfg_q.wet_gain   <= cfg_wdata_i[30:0];
        sog_pkg::CFG_DRY_GAIN:   cfg_q.dry_gain   <= cfg_wdata_i[30:0];
        sog_pkg::CFG_LIGHT_MODE: cfg_q.light_mode <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Step sequencer.
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    ch_d   = ch_q;
    if (accept) begin
      busy_d = 1'b1;
      pc_d   = '0;
      ch_d   = 1'b0;
    end else if (step_en) begin
      case (ctrl.flow)
        sog_pkg::FL_NEXT:  pc_d = pc_q + 1'b1;
        sog_pkg::FL_LIGHT: pc_d = cfg_q.light_mode ? sog_pkg::MIX_PC : pc_q + 1'b1;
        sog_pkg::FL_END: begin
          if (more) begin
            pc_d = '0;
            ch_d = 1'b1;
          end else begin
            busy_d = 1'b0;
          end
        end
        default: pc_d = pc_q + 1'b1;
      endcase
    end
  end

  // Output register. In mono the right sample passes through unchanged.
  always_comb begin
    m_valid_d = m_valid_q;
    m_left_d  = m_left_q;
    m_right_d = m_right_q;
    if (finish) begin
      m_valid_d = 1'b1;
      m_left_d  = ch_q ? dp_left : dp_out;
      m_right_d = ch_q ? dp_out : right_in_q;
    end else if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      pc_q      <= '0;
      ch_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      pc_q      <= pc_d;
      ch_q      <= ch_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      left_in_q  <= $signed(s_axis_tdata_i[SAMPLE_BITS-1:0]);
      right_in_q <= $signed(s_axis_tdata_i[2*SAMPLE_BITS-1:SAMPLE_BITS]);
      stereo_q   <= s_axis_tuser_i;
    end
    m_left_q  <= m_left_d;
    m_right_q <= m_right_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = DATA_W'({m_right_q, m_left_q});

endmodule

>>> design/sog_checker.sv
// Port-level checker of the sub-octave generator and its bind to the top level.
`timescale 1ns / 1ps

module sog_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  s_axis_tvalid_i,
  input logic                                  s_axis_tready_o,
  input logic                                  m_axis_tvalid_o,
  input logic                                  m_axis_tready_i,
  input logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    m_axis_tdata_o
);

  logic in_beat;
  assign in_beat = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled output beat keeps its valid and data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output beat changed while stalled");

  // Only one beat is in work at a time.
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !s_axis_tready_o)
    else $error("input taken while a beat is in work");

  // A result does not appear at once when a beat is taken.
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(m_axis_tvalid_o) ##1 !$rose(m_axis_tvalid_o))
    else $error("result appeared too early");

  // The block becomes ready again only by placing a result in a free output slot.
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s_axis_tready_o) |-> m_axis_tvalid_o &&
      ($past(!m_axis_tvalid_o) || $past(m_axis_tready_i)))
    else $error("ready returned without a delivered result");

endmodule

bind sub_octave_generator_top sog_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_sog_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
